>>> src/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// shared types and constants of the bilinear height sampler
// ----------------------------------------------------------------------------
package bhs_pkg;

    localparam int MAX_POINTS = 256;
    localparam int PTS_W      = $clog2(MAX_POINTS) + 1;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int ADDR_W     = 16;
    localparam int HEIGHT_W   = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_CELL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_READY    = 3'd3;

    localparam logic [8:0]  RESET_GRID_POINTS  = 9'd256;
    localparam logic [30:0] RESET_HALF_EXTENT  = 31'd16777216;
    localparam logic [31:0] RESET_INVERSE_CELL = 32'd32640;

    typedef struct packed {
        logic                       func;
        logic [ADDR_W-1:0]          entry_index;
        logic signed [HEIGHT_W-1:0] entry_height;
        logic signed [31:0]         query_x;
        logic signed [31:0]         query_z;
    } req_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       hit;
    } rsp_t;

endpackage

>>> src/bilinear_height_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_height_sampler
// height grid store with bilinear height queries in Q16.16
//
//   channel   ports                          handshake
//   request   start, busy, request            taken when start && !busy
//   result    done, result                   one-cycle strobe, no back-pressure
//   config    cfg_write, cfg_index, cfg_data taken when cfg_write
//
// a write request gives no result and leaves busy low
// a query inside the map gives its result after a multiply step, an index
// step, four corner reads on the single ram read port, a wait for the
// registered read data and three passes through the shared blend unit
// a query that misses gives its result in the next cycle and leaves busy low
// reset clears control and configuration, the height store is not cleared
// ----------------------------------------------------------------------------
module bilinear_height_sampler
    import bhs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  request,
    output logic                  done,
    output rsp_t                  result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_IDX,
        ST_READ,
        ST_WAIT,
        ST_TOP,
        ST_BOT,
        ST_MIX
    } state_t;

    state_t state_reg;

    logic [8:0]  grid_points_reg;
    logic [30:0] half_extent_reg;
    logic [31:0] inverse_cell_reg;
    logic        map_ready_reg;

    logic [31:0] x_off_reg;
    logic [31:0] z_off_reg;
    logic [47:0] gx_reg;
    logic [47:0] gz_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fz_reg;
    logic [IDX_W-1:0]  x0_reg;
    logic [IDX_W-1:0]  x1_reg;
    logic [IDX_W-1:0]  z0_reg;
    logic [IDX_W-1:0]  z1_reg;
    logic [1:0]        corner_reg;
    logic              rd_pend_reg;
    logic [1:0]        rd_corner_reg;
    logic signed [HEIGHT_W-1:0] h_reg [4];
    logic signed [HEIGHT_W-1:0] top_reg;
    logic              done_reg;
    rsp_t              result_reg;

    logic              accept;
    logic [PTS_W-1:0]  pts_eff;
    logic [IDX_W-1:0]  last;
    logic signed [32:0] xs;
    logic signed [32:0] zs;
    logic signed [32:0] hp;
    logic signed [32:0] hn;
    logic signed [32:0] x_sum;
    logic signed [32:0] z_sum;
    logic              in_square;
    logic [63:0]       x_prod;
    logic [63:0]       z_prod;
    logic [IDX_W-1:0]  x0_next;
    logic [IDX_W-1:0]  z0_next;
    logic [IDX_W-1:0]  xsel;
    logic [IDX_W-1:0]  zsel;
    logic [16:0]       row_base;
    logic [16:0]       addr_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [HEIGHT_W-1:0] rd_data;
    logic signed [HEIGHT_W-1:0] bl_a;
    logic signed [HEIGHT_W-1:0] bl_b;
    logic [FRAC_W-1:0] bl_f;
    logic signed [HEIGHT_W-1:0] bl_y;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // effective point count and last grid index
    always_comb
    begin
        if (grid_points_reg < PTS_W'(2))
        begin
            pts_eff = PTS_W'(2);
        end
        else if (grid_points_reg > PTS_W'(MAX_POINTS))
        begin
            pts_eff = PTS_W'(MAX_POINTS);
        end
        else
        begin
            pts_eff = grid_points_reg;
        end
    end

    assign last = IDX_W'(pts_eff - PTS_W'(1));

    // range check and offset into the square
    assign xs     = {request.query_x[31], request.query_x};
    assign zs     = {request.query_z[31], request.query_z};
    assign hp     = {2'b00, half_extent_reg};
    assign hn     = -hp;
    assign x_sum  = xs + hp;
    assign z_sum  = zs + hp;
    assign in_square = map_ready_reg && (xs >= hn) && (xs <= hp) && (zs >= hn) && (zs <= hp);

    assign x_prod = {32'b0, x_off_reg} * {32'b0, inverse_cell_reg};
    assign z_prod = {32'b0, z_off_reg} * {32'b0, inverse_cell_reg};

    // base cell, clamped to the last index
    assign x0_next = (gx_reg[47:16] > {{(32 - IDX_W){1'b0}}, last})
                   ? last : gx_reg[IDX_W+15:16];
    assign z0_next = (gz_reg[47:16] > {{(32 - IDX_W){1'b0}}, last})
                   ? last : gz_reg[IDX_W+15:16];

    // corner address, bit 0 picks the far column and bit 1 the far row
    assign xsel     = corner_reg[0] ? x1_reg : x0_reg;
    assign zsel     = corner_reg[1] ? z1_reg : z0_reg;
    assign row_base = 17'(zsel) * 17'(pts_eff);
    assign addr_sum = row_base + 17'(xsel);
    assign rd_addr  = addr_sum[ADDR_W-1:0];
    assign rd_en    = (state_reg == ST_READ);

    always_comb
    begin
        bl_a = h_reg[0];
        bl_b = h_reg[1];
        bl_f = fx_reg;
        case (state_reg)
            ST_BOT:
            begin
                bl_a = h_reg[2];
                bl_b = h_reg[3];
                bl_f = fx_reg;
            end
            ST_MIX:
            begin
                bl_a = top_reg;
                bl_b = h_reg[0];
                bl_f = fz_reg;
            end
            default:
            begin
                bl_a = h_reg[0];
                bl_b = h_reg[1];
                bl_f = fx_reg;
            end
        endcase
    end

    bhs_height_ram #(
        .DATA_W (HEIGHT_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (accept && (request.func == FUNC_WRITE)),
        .waddr (request.entry_index),
        .wdata (request.entry_height),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bhs_blend u_blend (
        .a    (bl_a),
        .b    (bl_b),
        .frac (bl_f),
        .y    (bl_y)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_points_reg  <= RESET_GRID_POINTS;
            half_extent_reg  <= RESET_HALF_EXTENT;
            inverse_cell_reg <= RESET_INVERSE_CELL;
            map_ready_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GRID_POINTS:  grid_points_reg  <= cfg_data[8:0];
                CFG_HALF_EXTENT:  half_extent_reg  <= cfg_data[30:0];
                CFG_INVERSE_CELL: inverse_cell_reg <= cfg_data;
                CFG_MAP_READY:    map_ready_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // query sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            corner_reg    <= 2'd0;
            rd_corner_reg <= 2'd0;
            x_off_reg     <= '0;
            z_off_reg     <= '0;
            gx_reg        <= '0;
            gz_reg        <= '0;
            fx_reg        <= '0;
            fz_reg        <= '0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            z0_reg        <= '0;
            z1_reg        <= '0;
            h_reg         <= '{default: '0};
            top_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= rd_en;
            if (rd_pend_reg)
            begin
                h_reg[rd_corner_reg] <= rd_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (request.func == FUNC_QUERY))
                    begin
                        if (in_square)
                        begin
                            x_off_reg <= x_sum[31:0];
                            z_off_reg <= z_sum[31:0];
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            done_reg          <= 1'b1;
                            result_reg.height <= '0;
                            result_reg.hit    <= 1'b0;
                        end
                    end
                end
                ST_MUL:
                begin
                    gx_reg    <= x_prod[63:16];
                    gz_reg    <= z_prod[63:16];
                    state_reg <= ST_IDX;
                end
                ST_IDX:
                begin
                    fx_reg     <= gx_reg[FRAC_W-1:0];
                    fz_reg     <= gz_reg[FRAC_W-1:0];
                    x0_reg     <= x0_next;
                    z0_reg     <= z0_next;
                    x1_reg     <= (x0_next == last) ? last : x0_next + IDX_W'(1);
                    z1_reg     <= (z0_next == last) ? last : z0_next + IDX_W'(1);
                    corner_reg <= 2'd0;
                    state_reg  <= ST_READ;
                end
                ST_READ:
                begin
                    rd_corner_reg <= corner_reg;
                    corner_reg    <= corner_reg + 2'd1;
                    if (corner_reg == 2'd3)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_TOP;
                end
                ST_TOP:
                begin
                    top_reg   <= bl_y;
                    state_reg <= ST_BOT;
                end
                ST_BOT:
                begin
                    h_reg[0]  <= bl_y;
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    done_reg          <= 1'b1;
                    result_reg.height <= bl_y;
                    result_reg.hit    <= 1'b1;
                    state_reg         <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/bhs_height_ram.sv
// ----------------------------------------------------------------------------
// bhs_height_ram
// height grid store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bhs_height_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bhs_blend.sv
// ----------------------------------------------------------------------------
// bhs_blend
// linear blend a + floor((b - a) * f / 2^16)
// ----------------------------------------------------------------------------
module bhs_blend
    import bhs_pkg::*;
(
    input  logic signed [HEIGHT_W-1:0] a,
    input  logic signed [HEIGHT_W-1:0] b,
    input  logic [FRAC_W-1:0]          frac,
    output logic signed [HEIGHT_W-1:0] y
);

    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;

    assign diff = {b[HEIGHT_W-1], b} - {a[HEIGHT_W-1], a};
    assign prod = $signed({{(FRAC_W + 1){diff[DIFF_W-1]}}, diff})
                * $signed({{DIFF_W{1'b0}}, 1'b0, frac});
    // floor shift, only the low bits matter since the blend stays in range
    assign y    = a + prod[FRAC_W+HEIGHT_W-1:FRAC_W];

endmodule

>>> tb/height_check_pkg.sv
// ----------------------------------------------------------------------------
// height_check_pkg
// scoreboard for the bilinear height sampler: keeps its own copy of the
// height grid and registers, predicts every query and checks the results
// in order
// ----------------------------------------------------------------------------
package height_check_pkg;

    import bhs_pkg::*;

    typedef struct packed {
        logic                          hit;
        logic [3:0][ADDR_W-1:0]        corner;
        logic [FRAC_W-1:0]             fx;
        logic [FRAC_W-1:0]             fz;
    } footprint_t;

    class height_scoreboard;

        localparam int REPORT_LIMIT = 10;

        logic [8:0]  grid_points;
        logic [30:0] half_extent;
        logic [31:0] inverse_cell;
        logic        map_ready;
        int          heights [1 << ADDR_W];
        rsp_t        expected [$];
        int unsigned errors;

        function new();
            grid_points  = RESET_GRID_POINTS;
            half_extent  = RESET_HALF_EXTENT;
            inverse_cell = RESET_INVERSE_CELL;
            map_ready    = 1'b0;
            errors       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_POINTS:  grid_points  = data[8:0];
                CFG_HALF_EXTENT:  half_extent  = data[30:0];
                CFG_INVERSE_CELL: inverse_cell = data;
                CFG_MAP_READY:    map_ready    = data[0];
                default: ;
            endcase
        endfunction

        // grid cell, corner addresses and fractions of a query
        function footprint_t locate(req_t r);
            footprint_t  fp;
            int unsigned pts;
            int unsigned last;
            longint      h;
            longint      x;
            longint      z;
            logic [63:0] gx;
            logic [63:0] gz;
            logic [63:0] cx0;
            logic [63:0] cx1;
            logic [63:0] cz0;
            logic [63:0] cz1;
            fp = '0;
            pts = grid_points;
            if (pts < 2)
                pts = 2;
            if (pts > MAX_POINTS)
                pts = MAX_POINTS;
            last = pts - 1;
            h = half_extent;
            x = $signed(r.query_x);
            z = $signed(r.query_z);
            if (!map_ready || x < -h || x > h || z < -h || z > h)
                return fp;
            gx = (64'(x + h) * 64'(inverse_cell)) >> FRAC_W;
            gz = (64'(z + h) * 64'(inverse_cell)) >> FRAC_W;
            cx0 = gx >> FRAC_W;
            if (cx0 > last)
                cx0 = last;
            cx1 = cx0 + 1;
            if (cx1 > last)
                cx1 = last;
            cz0 = gz >> FRAC_W;
            if (cz0 > last)
                cz0 = last;
            cz1 = cz0 + 1;
            if (cz1 > last)
                cz1 = last;
            fp.hit = 1'b1;
            fp.fx = gx[FRAC_W-1:0];
            fp.fz = gz[FRAC_W-1:0];
            fp.corner[0] = ADDR_W'(cz0 * pts + cx0);
            fp.corner[1] = ADDR_W'(cz0 * pts + cx1);
            fp.corner[2] = ADDR_W'(cz1 * pts + cx0);
            fp.corner[3] = ADDR_W'(cz1 * pts + cx1);
            return fp;
        endfunction

        // a + floor((b - a) * f / 2^16)
        function longint mix(longint a, longint b, logic [FRAC_W-1:0] f);
            longint w;
            w = f;
            return a + (((b - a) * w) >>> FRAC_W);
        endfunction

        function void note_request(req_t r);
            footprint_t fp;
            rsp_t       o;
            longint     top;
            longint     bot;
            if (r.func == FUNC_WRITE)
            begin
                heights[r.entry_index] = r.entry_height;
                return;
            end
            o = '0;
            fp = locate(r);
            if (fp.hit)
            begin
                top = mix(heights[fp.corner[0]], heights[fp.corner[1]], fp.fx);
                bot = mix(heights[fp.corner[2]], heights[fp.corner[3]], fp.fx);
                o.height = HEIGHT_W'(mix(top, bot, fp.fz));
                o.hit = 1'b1;
            end
            expected.insert(expected.size(), o);
        endfunction

        function void flag(string what, rsp_t want, rsp_t got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s: expected height %0d hit %0b, got height %0d hit %0b",
                         what, want.height, want.hit, got.height, got.hit);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = expected.pop_front();
            if (got.height !== want.height || got.hit !== want.hit)
                flag("result mismatch", want, got);
        endfunction

        function void close_out();
            while (expected.size() != 0)
                flag("missing result", expected.pop_front(), '0);
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

    endclass

endpackage

>>> tb/tb_bilinear_height_sampler.sv
// ----------------------------------------------------------------------------
// tb_bilinear_height_sampler
// self-checking bench for the bilinear height sampler: directed edge cases
// of the grid mapping and blend, then randomized grid writes and position
// queries over many register settings, with random start gaps; every query
// result is checked against a scoreboard that models the grid in software
// ----------------------------------------------------------------------------
module tb_bilinear_height_sampler;

    import bhs_pkg::*;
    import height_check_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int ITEM_TARGET   = 1700;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PERCENT  = 31;
    localparam int QUIET_SEGMENT = 3;

    typedef enum {COORD_SPAN, COORD_EDGE, COORD_WILD} coord_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  request   = '0;
    logic                  done;
    rsp_t                  result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    height_scoreboard sb = new();
    bit               written [1 << ADDR_W];
    bit               idling = 1'b1;
    int unsigned      items_sent = 0;
    int unsigned      stall_cycles = 0;

    bilinear_height_sampler dut (
        .clk,
        .rst_n,
        .start,
        .busy,
        .request,
        .done,
        .result,
        .cfg_write,
        .cfg_index,
        .cfg_data
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** bilinear_height_sampler: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_height();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 32'h7FFF_FFFF;
        if (roll == 1)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_coord(longint h, coord_mode_t mode);
        logic [63:0] roll;
        longint      v;
        roll = {$urandom, $urandom};
        case (mode)
            COORD_SPAN: v = longint'(roll % 64'(2 * h + 1)) - h;
            COORD_EDGE:
            begin
                case ($urandom_range(5))
                    0: v = -h;
                    1: v = h;
                    2: v = -h - 1;
                    3: v = h + 1;
                    4: v = h - 1;
                    default: v = 0;
                endcase
            end
            default: v = longint'(roll[31:0]);
        endcase
        return 32'(v);
    endfunction

    function automatic int unsigned fit_inverse(longint v);
        if (v < 1)
            return 1;
        if (v > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return 32'(v);
    endfunction

    function automatic req_t noise_req(logic func);
        req_t r;
        r.func         = func;
        r.entry_index  = ADDR_W'($urandom);
        r.entry_height = $urandom;
        r.query_x      = $urandom;
        r.query_z      = $urandom;
        return r;
    endfunction

    task automatic send(input req_t r);
        while (idling && $urandom_range(99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (r.func == FUNC_WRITE)
            written[r.entry_index] = 1'b1;
    endtask

    task automatic store_height(input logic [ADDR_W-1:0] idx, input logic [31:0] value);
        req_t r;
        r = noise_req(FUNC_WRITE);
        r.entry_index  = idx;
        r.entry_height = value;
        send(r);
    endtask

    // corners that have never been stored get a height first
    task automatic ask(input logic [31:0] x, input logic [31:0] z);
        req_t       r;
        footprint_t fp;
        r = noise_req(FUNC_QUERY);
        r.query_x = x;
        r.query_z = z;
        fp = sb.locate(r);
        if (fp.hit)
            for (int k = 0; k < 4; k++)
                if (!written[fp.corner[k]])
                    store_height(fp.corner[k], pick_height());
        send(r);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_map(input int unsigned pts, input int unsigned half,
                               input int unsigned inv, input bit ready);
        logic [CFG_IDX_W-1:0]  slot [5];
        logic [CFG_DATA_W-1:0] word [5];
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = $urandom;
        slot[0] = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_MAP_READY + 1));
        word[0] = $urandom;
        slot[1] = CFG_GRID_POINTS;
        word[1] = {junk[31:9], pts[8:0]};
        slot[2] = CFG_HALF_EXTENT;
        word[2] = {junk[0], half[30:0]};
        slot[3] = CFG_INVERSE_CELL;
        word[3] = inv;
        slot[4] = CFG_MAP_READY;
        word[4] = {junk[31:1], ready};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= slot[i];
            cfg_data  <= word[i];
            @(posedge clk);
            sb.set_register(slot[i], word[i]);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int unsigned seg;
        int unsigned count;
        int unsigned roll;
        int unsigned pts;
        int unsigned eff;
        int unsigned half;
        int unsigned inv;
        longint      matched;
        longint      jitter;
        bit          ready;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // map not loaded yet
        ask(32'h0, 32'h0);
        store_height(16'h0000, 32'h8000_0000);
        store_height(16'h0001, 32'h7FFF_FFFF);
        store_height(16'h0002, 32'h7FFF_FFFF);
        store_height(16'h0003, 32'h8000_0000);
        store_height(16'hFFFF, pick_height());

        // smallest grid, full-range height steps
        program_map(2, 32'h1_0000, 32'h8000, 1'b1);
        ask(32'hFFFF_0000, 32'hFFFF_0000);
        ask(32'h0001_0000, 32'h0001_0000);
        ask(32'h0, 32'h0);
        ask(32'h0000_FFFF, 32'hFFFF_0001);
        ask(32'h0001_0001, 32'h0);
        ask(32'h0, 32'hFFFE_FFFF);
        ask(32'h7FFF_FFFF, 32'h8000_0000);

        // point count below range, widest square, smallest scale
        program_map(0, 32'h7FFF_FFFF, 1, 1'b1);
        ask(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        ask(32'h8000_0001, 32'h8000_0001);
        ask(32'h8000_0000, 32'h0);

        // point count above range, tiny square, largest scale
        program_map(511, 1, 32'hFFFF_FFFF, 1'b1);
        ask(32'h1, 32'h1);
        ask(32'hFFFF_FFFF, 32'h0);
        ask(32'h2, 32'h0);

        seg = 0;
        while (items_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                pts = $urandom_range(16, 2);
            else if (roll < 75)
                pts = $urandom_range(64, 17);
            else if (roll < 85)
                pts = MAX_POINTS;
            else if (roll < 92)
                pts = $urandom_range(1, 0);
            else
                pts = $urandom_range(511, MAX_POINTS + 1);
            eff = (pts < 2) ? 2 : ((pts > MAX_POINTS) ? MAX_POINTS : pts);

            roll = $urandom_range(99);
            if (roll < 50)
                half = $urandom_range(32'h10_0000, 32'h8000);
            else if (roll < 65)
                half = $urandom_range(32'hFFFF, 1);
            else if (roll < 80)
                half = $urandom_range(32'h7FFF_FFFF, 1);
            else if (roll < 90)
                half = 32'h7FFF_FFFF;
            else
                half = 1;

            matched = fit_inverse((longint'(eff - 1) << 31) / half);
            jitter = matched >> 3;
            roll = $urandom_range(99);
            if (roll < 60)
                inv = 32'(matched);
            else if (roll < 75)
                inv = fit_inverse(matched + longint'($urandom_range(32'(2 * jitter))) - jitter);
            else if (roll < 85)
                inv = fit_inverse(longint'($urandom));
            else if (roll < 92)
                inv = 32'hFFFF_FFFF;
            else
                inv = 1;

            ready = ($urandom_range(99) < 88);
            idling = (seg != QUIET_SEGMENT);
            count = (seg == QUIET_SEGMENT) ? 200 : $urandom_range(90, 40);
            program_map(pts, half, inv, ready);

            repeat (count)
            begin
                roll = $urandom_range(99);
                if (roll < 2)
                    settle();
                else if (roll < 17)
                    store_height(ADDR_W'($urandom), pick_height());
                else if (roll < 27)
                    ask(pick_coord(half, COORD_WILD), pick_coord(half, COORD_WILD));
                else if (roll < 32)
                    ask(pick_coord(half, COORD_EDGE),
                        pick_coord(half, coord_mode_t'($urandom_range(1))));
                else if (roll < 37)
                    ask(pick_coord(half, COORD_SPAN), pick_coord(half, COORD_EDGE));
                else
                    ask(pick_coord(half, COORD_SPAN), pick_coord(half, COORD_SPAN));
            end
            seg++;
        end

        settle();
        sb.close_out();
        if (sb.errors == 0)
            $display("** bilinear_height_sampler: PASSED **");
        else
            $display("** bilinear_height_sampler: FAILED **");
        $finish;
    end

endmodule
